[design/nfe_pkg.sv]
package nfe_pkg;

   // One accepted input word, as held in the input register.
   typedef struct packed {
      logic       action;     // 0 = frame start, 1 = payload byte
      logic       is_idr;
      logic [7:0] data_byte;
   } item_type;

   // One generated output byte on its way to the output register.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } beat_type;

   localparam logic ACTION_FRAME   = 1'b0;
   localparam logic ACTION_PAYLOAD = 1'b1;

   // Byte position within the words caused by one input word.
   localparam int unsigned POS_W = 3;
   localparam logic [POS_W-1:0] POS_FIRST       = 3'd0;
   localparam logic [POS_W-1:0] POS_START_LAST  = 3'd3;
   localparam logic [POS_W-1:0] POS_HDR_0       = 3'd4;
   localparam logic [POS_W-1:0] POS_HDR_1       = 3'd5;
   localparam logic [POS_W-1:0] POS_HDR_2       = 3'd6;
   localparam logic [POS_W-1:0] POS_FRAME_LAST  = 3'd7;
   localparam logic [POS_W-1:0] POS_ESCAPE_LAST = 3'd1;

   localparam logic [7:0] BYTE_ZERO       = 8'h00;
   localparam logic [7:0] START_CODE_LAST = 8'h01;
   localparam logic [7:0] EPB_BYTE        = 8'h03;

   localparam logic [7:0] IDR_HDR_0 = 8'h25;
   localparam logic [7:0] IDR_HDR_1 = 8'hB8;
   localparam logic [7:0] IDR_HDR_2 = 8'h04;
   localparam logic [7:0] P_HDR_0   = 8'h21;
   localparam logic [7:0] P_HDR_1   = 8'hE0;
   localparam logic [7:0] P_HDR_2   = 8'h03;
   localparam logic [7:0] HDR_3     = 8'hFF;

   localparam logic [1:0] ZERO_RUN_MAX = 2'd2;

endpackage

[design/h264_nal_frame_escaper.sv]
// H.264 slice framer with emulation prevention. Each input word either starts a
// frame (req_tuser bit 0 low) or carries one payload byte in req_tdata. A frame
// start produces eight output words: the start code 00 00 00 01 followed by a
// four-byte slice header prefix, 25 B8 04 FF for an IDR frame (which clears the
// 8-bit frame counter) or 21 E0 03 FF with the advanced counter merged into the
// second and third bytes for a P frame. A payload byte produces one output word,
// or two when it is 00..03 and follows two zero payload bytes, in which case an
// 03 byte is inserted ahead of it. Header bytes do not count toward the zero run,
// and the run restarts at each frame start. rsp_tlast marks the final output word
// caused by each input word. The block holds one input word in an input register
// while a small byte generator emits its output bytes into an output register,
// one per cycle whenever that register can take a byte, so the output port sets
// the pace. The next input word is accepted in the same cycle that the held word
// hands its final byte to the output register, so back-to-back words leave the
// byte generator no idle gap.
module h264_nal_frame_escaper
   import nfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic [1:0] req_tuser,   // [0] action, [1] is_idr
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast
);

   item_type in_item;
   item_type item;
   logic     item_valid;
   logic     item_done;
   logic     step;
   beat_type beat;
   beat_type out_beat;

   assign in_item.action    = req_tuser[0];
   assign in_item.is_idr    = req_tuser[1];
   assign in_item.data_byte = req_tdata;

   // Input register: holds the word whose output bytes are being generated.
   nfe_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .item_valid (item_valid),
      .item       (item),
      .item_done  (item_done)
   );

   // Byte generator: walks the output positions of the held word and keeps the
   // frame counter and zero-run state, which advance when the word completes.
   nfe_byte_gen u_byte_gen (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .step       (step),
      .beat       (beat),
      .item_done  (item_done)
   );

   // Output register: decouples the generator from backpressure on rsp_tready.
   nfe_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (item_valid),
      .beat       (beat),
      .step       (step),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_beat   (out_beat)
   );

   assign rsp_tdata = out_beat.out_byte;
   assign rsp_tlast = out_beat.last;

endmodule

[design/nfe_in_stage.sv]
module nfe_in_stage
   import nfe_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     item_valid,
   output item_type item,
   input  logic     item_done
);

   logic     vld_ff, vld_in;
   item_type item_ff;

   // A new word may enter while the held one hands off its final byte.
   assign in_ready = !vld_ff || item_done;

   always_comb begin
      vld_in = vld_ff;
      if (item_done) begin
         vld_in = 1'b0;
      end
      if (in_valid && in_ready) begin
         vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign item_valid = vld_ff;
   assign item       = item_ff;

endmodule

[design/nfe_byte_gen.sv]
module nfe_byte_gen
   import nfe_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     item_valid,
   input  item_type item,
   input  logic     step,
   output beat_type beat,
   output logic     item_done
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       frame_count_ff, frame_count_in;
   logic [1:0]       zero_run_ff, zero_run_in;

   logic [7:0]       count_next;
   logic [7:0]       count_shl;
   logic             escape;
   logic [POS_W-1:0] last_pos;
   logic [7:0]       byte_val;
   logic             is_last;

   assign count_next = frame_count_ff + 8'd1;
   assign count_shl  = {count_next[2:0], 5'd0};

   // A run value of three cannot occur, and the high bit treats it as two.
   assign escape = zero_run_ff[1] && (item.data_byte <= EPB_BYTE);

   always_comb begin
      if (item.action == ACTION_FRAME) begin
         last_pos = POS_FRAME_LAST;
      end else if (escape) begin
         last_pos = POS_ESCAPE_LAST;
      end else begin
         last_pos = POS_FIRST;
      end
   end

   assign is_last = (pos_ff == last_pos);

   always_comb begin
      byte_val = BYTE_ZERO;
      if (item.action == ACTION_FRAME) begin
         case (pos_ff)
            POS_START_LAST: byte_val = START_CODE_LAST;
            POS_HDR_0:      byte_val = item.is_idr ? IDR_HDR_0 : P_HDR_0;
            POS_HDR_1:      byte_val = item.is_idr ? IDR_HDR_1
                                                   : (P_HDR_1 | {3'd0, count_next[7:3]});
            POS_HDR_2:      byte_val = item.is_idr ? IDR_HDR_2 : (P_HDR_2 | count_shl);
            POS_FRAME_LAST: byte_val = HDR_3;
            default:        byte_val = BYTE_ZERO;
         endcase
      end else if (escape && (pos_ff == POS_FIRST)) begin
         byte_val = EPB_BYTE;
      end else begin
         byte_val = item.data_byte;
      end
   end

   assign beat.out_byte = byte_val;
   assign beat.last     = is_last;
   assign item_done     = item_valid && step && is_last;

   always_comb begin
      pos_in         = pos_ff;
      frame_count_in = frame_count_ff;
      zero_run_in    = zero_run_ff;
      if (item_valid && step) begin
         pos_in = is_last ? POS_FIRST : pos_ff + 3'd1;
      end
      if (item_done) begin
         if (item.action == ACTION_FRAME) begin
            frame_count_in = item.is_idr ? 8'd0 : count_next;
            zero_run_in    = 2'd0;
         end else if (item.data_byte == BYTE_ZERO) begin
            // After an inserted byte the run restarts and this zero counts once.
            if (escape) begin
               zero_run_in = 2'd1;
            end else if (zero_run_ff[1]) begin
               zero_run_in = ZERO_RUN_MAX;
            end else begin
               zero_run_in = zero_run_ff + 2'd1;
            end
         end else begin
            zero_run_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= POS_FIRST;
         frame_count_ff <= 8'd0;
         zero_run_ff    <= 2'd0;
      end else begin
         pos_ff         <= pos_in;
         frame_count_ff <= frame_count_in;
         zero_run_ff    <= zero_run_in;
      end
   end

endmodule

[design/nfe_out_stage.sv]
module nfe_out_stage
   import nfe_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     beat_valid,
   input  beat_type beat,
   output logic     step,
   output logic     out_valid,
   input  logic     out_ready,
   output beat_type out_beat
);

   logic     vld_ff, vld_in;
   beat_type beat_ff;

   // The register loads whenever it is empty or its word is taken this cycle.
   assign step = !vld_ff || out_ready;

   always_comb begin
      vld_in = vld_ff;
      if (step) begin
         vld_in = beat_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && beat_valid) begin
         beat_ff <= beat;
      end
   end

   assign out_valid = vld_ff;
   assign out_beat  = beat_ff;

endmodule
